// File: sv/atrm_pkg.sv
// ----------------------------------------------------------------------------
// AT response matcher package
// Shared types, codes and pattern tables for the AT response matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package atrm_pkg;

    localparam int PAT_COUNT = 6;
    localparam int PROG_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int TICK_W    = 16;

    localparam logic [TICK_W-1:0]  WAIT_TICKS_RESET = 16'd2000;
    localparam logic [CHAR_W-1:0]  CHAR_CR          = 8'h0D;
    localparam logic [CHAR_W-1:0]  CHAR_NUL         = 8'h00;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'hFF;
    localparam logic [TICK_W-1:0]  TICK_MAX         = 16'hFFFF;

    localparam int PAT_OK     = 0;
    localparam int PAT_ERROR  = 1;
    localparam int PAT_READY  = 2;
    localparam int PAT_SIMPIN = 3;
    localparam int PAT_CREG   = 4;
    localparam int PAT_RDYCOL = 5;

    localparam logic [PAT_COUNT-1:0] TERM_MASK = 6'h1F;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_CHAR   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_SUCCESS = 2'd0,
        ST_ERROR   = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_UNCLASS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LISTEN  = 2'd1,
        PH_PENDING = 2'd2
    } t_phase;

    function automatic logic [PROG_W-1:0] pat_len(input logic [2:0] idx);
        logic [PROG_W-1:0] len;
        unique case (idx)
            3'd0:    len = 3'd2;
            3'd1:    len = 3'd6;
            3'd2:    len = 3'd5;
            3'd3:    len = 3'd7;
            3'd4:    len = 3'd5;
            3'd5:    len = 3'd6;
            default: len = 3'd7;
        endcase
        return len;
    endfunction

    function automatic logic [CHAR_W-1:0] pat_char(input logic [2:0] idx,
                                                   input logic [PROG_W-1:0] pos);
        logic [7*CHAR_W-1:0] text;
        unique case (idx)
            3'd0:    text = {"OK", 40'h0};
            3'd1:    text = {"ERROR:", 8'h0};
            3'd2:    text = {"READY", 16'h0};
            3'd3:    text = "SIM PIN";
            3'd4:    text = {"+CREG", 16'h0};
            3'd5:    text = {"READY:", 8'h0};
            default: text = '0;
        endcase
        return text[(7 - 32'(pos))*CHAR_W - 1 -: CHAR_W];
    endfunction

endpackage

`default_nettype wire

// File: sv/at_response_matcher_unit.sv
// ----------------------------------------------------------------------------
// AT response matcher unit
// Follows a modem reply character by character, tracks six reply patterns and
// reports success, error, timeout or an unclassified reply for each session.
// ----------------------------------------------------------------------------
// A result is registered: the input register, the matcher update and the result
// register lie between the input transfer that ends the session and its result.
// Throughput: one input transfer per cycle; the input side stalls only while a
// result is held and the output side stalls.
// Reset clears the session state and loads the wait limit with 2000 ticks.
`default_nettype none

module at_response_matcher_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [1:0]                      i_command,
    input  wire  [atrm_pkg::CHAR_W-1:0]     i_rx_char,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [1:0]                      o_status,
    output logic [atrm_pkg::COUNT_W-1:0]    o_char_count,
    input  wire                             i_wait_ticks_we,
    input  wire  [atrm_pkg::TICK_W-1:0]     i_wait_ticks
);
    import atrm_pkg::*;

    logic                   r_in_valid;
    t_cmd                   r_cmd;
    logic [CHAR_W-1:0]      r_ch;

    logic [TICK_W-1:0]      r_wait_ticks;
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [TICK_W-1:0]      r_elapsed;
    logic [TICK_W-1:0]      n_elapsed;
    logic [PROG_W-1:0]      r_prog [PAT_COUNT];
    logic [PROG_W-1:0]      n_prog [PAT_COUNT];
    logic [PAT_COUNT-1:0]   r_seen;
    logic [PAT_COUNT-1:0]   n_seen;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;

    logic                   r_out_valid;
    t_status                r_status;
    logic [COUNT_W-1:0]     r_out_count;
    logic                   n_result;
    t_status                n_status;

    logic                   proc_en;

    assign proc_en      = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall      = r_in_valid && r_out_valid && i_stall;
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_char_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_cmd <= t_cmd'(i_command);
            r_ch  <= i_rx_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_TICKS_RESET;
        end else if (i_wait_ticks_we) begin
            r_wait_ticks <= i_wait_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_seen    <= '0;
            r_count   <= '0;
            for (int i = 0; i < PAT_COUNT; i++) begin
                r_prog[i] <= '0;
            end
        end else if (proc_en) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_seen    <= n_seen;
            r_count   <= n_count;
            for (int i = 0; i < PAT_COUNT; i++) begin
                r_prog[i] <= n_prog[i];
            end
        end
    end

    always_comb begin
        logic [PROG_W-1:0]    p;
        logic [PAT_COUNT-1:0] seen_upd;
        logic [PROG_W-1:0]    prog_upd [PAT_COUNT];
        logic [TICK_W-1:0]    tick_upd;

        seen_upd = r_seen;
        for (int i = 0; i < PAT_COUNT; i++) begin
            p = r_prog[i];
            if (p >= pat_len(3'(i))) begin
                p = '0;
            end
            if (pat_char(3'(i), p) == r_ch) begin
                p = p + 3'd1;
            end else if (pat_char(3'(i), 3'd0) == r_ch) begin
                p = 3'd1;
            end else begin
                p = 3'd0;
            end
            if (p >= pat_len(3'(i))) begin
                seen_upd[i] = 1'b1;
                p = '0;
            end
            prog_upd[i] = p;
        end

        tick_upd = (r_elapsed != TICK_MAX) ? r_elapsed + 16'd1 : r_elapsed;

        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_seen    = r_seen;
        n_count   = r_count;
        n_prog    = r_prog;
        n_result  = 1'b0;
        n_status  = ST_UNCLASS;

        if (r_cmd == CMD_START) begin
            n_phase   = PH_LISTEN;
            n_elapsed = '0;
            n_seen    = '0;
            n_count   = '0;
            for (int i = 0; i < PAT_COUNT; i++) begin
                n_prog[i] = '0;
            end
        end else if (r_phase != PH_IDLE) begin
            unique case (r_cmd)
                CMD_TICK: begin
                    n_elapsed = tick_upd;
                    if (tick_upd >= r_wait_ticks) begin
                        n_phase  = PH_IDLE;
                        n_result = 1'b1;
                        n_status = ST_TIMEOUT;
                    end
                end
                CMD_CHAR: begin
                    if (r_ch != CHAR_NUL) begin
                        n_count = (r_count != COUNT_MAX) ? r_count + 8'd1 : r_count;
                        n_seen  = seen_upd;
                        n_prog  = prog_upd;
                        if (r_phase == PH_PENDING && r_ch == CHAR_CR) begin
                            n_phase  = PH_IDLE;
                            n_result = 1'b1;
                            if (seen_upd[PAT_OK] || seen_upd[PAT_RDYCOL]) begin
                                n_status = ST_SUCCESS;
                            end else if (seen_upd[PAT_ERROR]) begin
                                n_status = ST_ERROR;
                            end else begin
                                n_status = ST_UNCLASS;
                            end
                        end else if (r_phase != PH_PENDING &&
                                     (seen_upd & TERM_MASK) != '0) begin
                            n_phase = PH_PENDING;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && n_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_en && n_result) begin
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: sv/atrm_checker.sv
// ----------------------------------------------------------------------------
// AT response matcher checker
// Port-level assertions for the AT response matcher unit, bound to the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module atrm_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [1:0] o_status,
    input wire [7:0] o_char_count
);
    import atrm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_char_count))
        else $error("Result changed while its transfer was stalled.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled without a held result.");

    a_success_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SUCCESS |-> o_char_count >= 8'd3)
        else $error("Success reported on a reply that is too short.");

    a_error_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ERROR |-> o_char_count >= 8'd7)
        else $error("Error reported on a reply that is too short.");

    a_unclass_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_UNCLASS |-> o_char_count >= 8'd6)
        else $error("Unclassified reply reported on a reply that is too short.");

endmodule

bind at_response_matcher_unit atrm_checker u_atrm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_char_count (o_char_count)
);

`default_nettype wire

// File: tb/tb_at_response_matcher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AT response matcher unit testbench
// Drives sessions of start, character, tick and unused transfers into the matcher,
// predicts each session outcome in step with the accepted transfers and checks
// every result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module tb_at_response_matcher_unit;

    import atrm_pkg::*;

    localparam int HOLD_CYCLES    = 240;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] ch;
    } rx_item_t;

    typedef struct packed {
        t_status    status;
        logic [7:0] count;
    } reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = CMD_UNUSED;
    logic [7:0]  i_rx_char = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_char_count;
    logic        i_wait_ticks_we = 1'b0;
    logic [15:0] i_wait_ticks = 16'h0000;

    rx_item_t tx_items[$];
    reply_t   pending_replies[$];
    rx_item_t offer = '{cmd: CMD_UNUSED, ch: 8'h00};

    int errors = 0;
    int issued = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;

    t_phase      sess_phase = PH_IDLE;
    logic [15:0] sess_ticks = '0;
    logic [2:0]  match_pos[PAT_COUNT] = '{default: '0};
    logic [5:0]  seen_mask = '0;
    logic [7:0]  char_total = '0;
    logic [15:0] wait_limit = WAIT_TICKS_RESET;

    at_response_matcher_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_rx_char      (i_rx_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_char_count   (o_char_count),
        .i_wait_ticks_we(i_wait_ticks_we),
        .i_wait_ticks   (i_wait_ticks)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic string pattern_text(input int idx);
        case (idx)
            PAT_OK:     return "OK";
            PAT_ERROR:  return "ERROR:";
            PAT_READY:  return "READY";
            PAT_SIMPIN: return "SIM PIN";
            PAT_CREG:   return "+CREG";
            PAT_RDYCOL: return "READY:";
            default:    return "";
        endcase
    endfunction

    task automatic predict_reply(input t_cmd cmd, input logic [7:0] ch);
        reply_t r;
        string  s;
        int     p;
        bit     was_pending;
        if (cmd == CMD_START) begin
            sess_phase = PH_LISTEN;
            sess_ticks = '0;
            match_pos  = '{default: '0};
            seen_mask  = '0;
            char_total = '0;
        end else if (sess_phase != PH_IDLE && cmd == CMD_TICK) begin
            if (sess_ticks != TICK_MAX) sess_ticks++;
            if (sess_ticks >= wait_limit) begin
                sess_phase = PH_IDLE;
                r.status = ST_TIMEOUT;
                r.count  = char_total;
                pending_replies.push_back(r);
            end
        end else if (sess_phase != PH_IDLE && cmd == CMD_CHAR && ch != CHAR_NUL) begin
            if (char_total != COUNT_MAX) char_total++;
            was_pending = (sess_phase == PH_PENDING);
            for (int i = 0; i < PAT_COUNT; i++) begin
                s = pattern_text(i);
                p = match_pos[i];
                if (p >= s.len()) p = 0;
                if (s[p] == ch) p++;
                else p = (s[0] == ch) ? 1 : 0;
                if (p >= s.len()) begin
                    seen_mask[i] = 1'b1;
                    p = 0;
                end
                match_pos[i] = p[2:0];
            end
            if (was_pending && ch == CHAR_CR) begin
                if (seen_mask[PAT_OK] || seen_mask[PAT_RDYCOL]) r.status = ST_SUCCESS;
                else if (seen_mask[PAT_ERROR]) r.status = ST_ERROR;
                else r.status = ST_UNCLASS;
                r.count = char_total;
                sess_phase = PH_IDLE;
                pending_replies.push_back(r);
            end else if (!was_pending && (seen_mask[4:0] & TERM_MASK[4:0]) != 0) begin
                sess_phase = PH_PENDING;
            end
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic next_valid;
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_reply(offer.cmd, offer.ch);
            if (!i_valid || !o_stall) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tx_items.size() != 0) begin
                    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
                        gap_left = $urandom_range(1, 13) - 1;
                    end else begin
                        offer = tx_items.pop_front();
                        next_valid = 1'b1;
                    end
                end
                i_valid   <= next_valid;
                i_command <= offer.cmd;
                i_rx_char <= offer.ch;
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        reply_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result, status %0d, count %0d",
                         $time, o_status, o_char_count);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status != want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_char_count != want.count) begin
                    $display("%0t: char_count mismatch, expected %0d, actual %0d",
                             $time, want.count, o_char_count);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("** at_response_matcher_unit: FAILED **");
        $finish;
    end

    task automatic push_item(input t_cmd cmd, input logic [7:0] ch);
        rx_item_t it;
        it.cmd = cmd;
        it.ch  = ch;
        tx_items.push_back(it);
        issued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_item(CMD_CHAR, s[i]);
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain;
        @(negedge i_clk);
        while (tx_items.size() != 0 || i_valid || pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_wait_limit(input logic [15:0] value);
        @(posedge i_clk);
        i_wait_ticks_we <= 1'b1;
        i_wait_ticks    <= value;
        wait_limit = value;
        @(posedge i_clk);
        i_wait_ticks_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic add_session(input int limit);
        string s;
        int    n;
        int    k;
        if ($urandom_range(0, 19) == 0)
            push_item(t_cmd'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        push_item(CMD_START, 8'($urandom_range(0, 255)));
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_text(pattern_text($urandom_range(0, PAT_COUNT - 1)));
                4: begin
                    s = pattern_text($urandom_range(0, PAT_COUNT - 1));
                    push_text(s.substr(0, $urandom_range(0, s.len() - 2)));
                end
                5: begin
                    k = $urandom_range(1, 4);
                    for (int j = 0; j < k; j++) push_item(CMD_CHAR, 8'($urandom_range(32, 126)));
                end
                6: push_item(CMD_CHAR, 8'($urandom_range(0, 255)));
                7: push_item(CMD_CHAR, $urandom_range(0, 1) ? CHAR_CR : CHAR_NUL);
                8: push_ticks($urandom_range(1, 3));
                default: push_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: push_item(CMD_CHAR, CHAR_CR);
            7: ;
            8: if (limit <= 60) push_ticks(limit);
            default: begin
                push_item(CMD_CHAR, 8'($urandom_range(1, 255)));
                push_item(CMD_CHAR, CHAR_CR);
            end
        endcase
    endtask

    initial begin : stimulus
        int wl;
        int first;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 20;
        push_text("OK\r");
        push_item(CMD_TICK, 8'h00);
        push_item(CMD_UNUSED, 8'hFF);
        push_item(CMD_START, 8'h00);
        push_text("OK\r");
        push_item(CMD_START, 8'hFF);
        push_item(CMD_CHAR, CHAR_CR);
        push_text("ERROR:");
        push_item(CMD_CHAR, CHAR_NUL);
        push_item(CMD_CHAR, CHAR_CR);
        push_item(CMD_START, 8'h00);
        push_text("REA");
        push_item(CMD_START, 8'h00);
        push_text("READY:\r");
        push_item(CMD_START, 8'h00);
        push_text("OK");
        push_item(CMD_UNUSED, CHAR_CR);
        push_text("ERROR:\r");
        push_item(CMD_START, 8'h00);
        push_text("SIM PIN");
        push_item(CMD_CHAR, 8'hFF);
        push_item(CMD_CHAR, CHAR_CR);
        push_item(CMD_START, 8'h00);
        push_text("+CREG\r");
        push_item(CMD_START, 8'h00);
        push_text("READY\r");
        push_item(CMD_START, 8'h00);
        push_text("ER");
        push_ticks(5);
        drain();

        write_wait_limit(16'h0000);
        push_item(CMD_START, 8'h00);
        push_item(CMD_TICK, 8'hFF);
        push_item(CMD_TICK, 8'h00);
        push_item(CMD_START, 8'h00);
        push_text("x");
        push_item(CMD_TICK, 8'h00);
        drain();

        write_wait_limit(16'd5);
        push_item(CMD_START, 8'h00);
        push_text("AT");
        push_ticks(3);
        drain();
        write_wait_limit(16'd2);
        push_ticks(1);
        drain();

        write_wait_limit(16'hFFFF);
        send_idle_pct = 2;
        recv_idle_pct = 2;
        push_item(CMD_START, 8'h00);
        push_text("OK");
        for (int i = 0; i < 260; i++) push_item(CMD_CHAR, "A");
        push_item(CMD_CHAR, CHAR_CR);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: wl = $urandom_range(1, 8);
                1: wl = $urandom_range(20, 200);
                2: wl = 65535;
                3: wl = 0;
                4: wl = $urandom_range(0, 65535);
                default: wl = $urandom_range(2, 50);
            endcase
            write_wait_limit(16'(wl));
            send_idle_pct = (p == 1) ? 0 : $urandom_range(0, 2) * 15;
            recv_idle_pct = (p == 1) ? 0 : $urandom_range(0, 2) * 15;
            calm = (p == 5);
            first = issued;
            while (issued - first < 75) add_session(wl);
            if (p == 1) begin
                @(posedge i_clk);
                hold_req <= ~hold_req;
            end
            if (p == 2) drain();
            while (issued - first < 150) add_session(wl);
            drain();
        end

        if (errors == 0) begin
            $display("** at_response_matcher_unit: PASSED **");
        end else begin
            $display("** at_response_matcher_unit: FAILED **");
        end
        $finish;
    end

endmodule
